// ===== rtl/core/pdjs_pkg.sv =====
// ----------------------------------------------------------------------------
// pdjs_pkg
// Shared constants of the pair dependency job scheduler.
// ----------------------------------------------------------------------------
package pdjs_pkg;
  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int CFG_W = 7;
  localparam int OP_W = 2;
  localparam int SYM_W = 6;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_FETCH = 2'd2;
  localparam logic [OP_W-1:0] OP_DONE = 2'd3;

  localparam logic [ST_W-1:0] ST_JOB = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_ALLDONE = 2'd2;
  localparam logic [ST_W-1:0] ST_ACK = 2'd3;

  localparam logic [1:0] CFG_ORIG = 2'd0;
  localparam logic [1:0] CFG_TOTAL = 2'd1;
  localparam logic [1:0] CFG_WORKERS = 2'd2;
endpackage

// ===== rtl/core/pdjs_divider.sv =====
// ----------------------------------------------------------------------------
// pdjs_divider
// Restoring divider, one quotient bit per cycle, for the fetch batch size.
// ----------------------------------------------------------------------------
module pdjs_divider #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);
  logic [W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [$clog2(W+1)-1:0] cnt_r, cnt_nxt;
  logic [W:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    trial = {rem_r, quo_r[W-1]};
    if (cnt_r != '0) begin
      quo_nxt = {quo_r[W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = W'(trial - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= ($clog2(W+1))'(W);
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quotient = quo_r;
endmodule

// ===== rtl/core/pair_dependency_job_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// pair_dependency_job_scheduler_unit
// Dataflow scheduler for pair symbols with a LIFO ready stack in memory.
// ----------------------------------------------------------------------------
// Operation: a load is answered with an ack beat; a start scans the pair
//   memory once, reading and then evaluating each pair symbol; a completion
//   scans it twice; a fetch first computes the batch size with the
//   bit-serial divider, then pops each job from the stack memory.
// Throughput: one item at a time; in_stall holds off a new item until the
//   sequencer is back in its idle state.
// Reset: synchronous, active low; flags and counters take their reset values
//   at once, the pair and stack memories are undefined until written.
// ----------------------------------------------------------------------------
module pair_dependency_job_scheduler_unit #(
  parameter int MAX_SYMBOLS = pdjs_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pdjs_pkg::OP_W-1:0]  in_op,
  input  logic [pdjs_pkg::SYM_W-1:0] in_symbol,
  input  logic [pdjs_pkg::SYM_W-1:0] in_operand_first,
  input  logic [pdjs_pkg::SYM_W-1:0] in_operand_second,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pdjs_pkg::SYM_W-1:0] out_job_symbol,
  output logic [pdjs_pkg::ST_W-1:0]  out_status,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [pdjs_pkg::CFG_W-1:0] cfg_data
);
  import pdjs_pkg::*;

  localparam int IW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  // The batch numerator is depth plus workers minus one, which needs a bit
  // more than a count register.
  localparam int DW = CFG_W + 1;
  // Reset original count of 4, clamped to the table size.
  localparam int ORIG_RST = (MAX_SYMBOLS < 4) ? MAX_SYMBOLS : 4;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_EV = 4'd2;
  localparam logic [3:0] S_DIV = 4'd3;
  localparam logic [3:0] S_POP_RD = 4'd4;
  localparam logic [3:0] S_POP_OUT = 4'd5;
  localparam logic [3:0] S_OUT = 4'd6;
  localparam logic [3:0] S_DIV_GO = 4'd7;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [CFG_W-1:0] orig_cfg_r, total_cfg_r, work_cfg_r;
  logic [CW-1:0] orig_c, total_c;
  logic [CFG_W-1:0] workers;

  assign orig_c = (orig_cfg_r > CFG_W'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : CW'(orig_cfg_r);
  assign total_c = (total_cfg_r > CFG_W'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : CW'(total_cfg_r);
  assign workers = (work_cfg_r == '0) ? CFG_W'(1) : work_cfg_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orig_cfg_r <= CFG_W'(4);
      total_cfg_r <= CFG_W'(4);
      work_cfg_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIG: orig_cfg_r <= cfg_data;
        CFG_TOTAL: total_cfg_r <= cfg_data;
        CFG_WORKERS: work_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flags live in flip-flops so both operands can be looked up together.
  logic [MAX_SYMBOLS-1:0] comp_r, added_r;
  logic [CW-1:0] depth_r;
  logic [CFG_W-1:0] fetched_r;

  // Pair memory: one entry holds both operands; one read port.
  logic [2*SYM_W-1:0] pair_mem [MAX_SYMBOLS];
  logic [2*SYM_W-1:0] pair_q;
  logic [IW-1:0] pair_raddr;
  logic pair_we;

  // Ready stack memory.
  logic [SYM_W-1:0] stack_mem [MAX_SYMBOLS];
  logic [SYM_W-1:0] stack_q;
  logic stack_we;
  logic [IW-1:0] stack_raddr;

  // Item being worked on.
  logic [OP_W-1:0] op_r;
  logic [SYM_W-1:0] sym_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic pass_r, pass_nxt;
  logic [CW-1:0] batch_r, batch_nxt;

  // Output register.
  logic out_valid_r;
  logic [SYM_W-1:0] out_sym_r;
  logic [ST_W-1:0] out_st_r;
  logic out_last_r;

  logic in_acc, out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;

  // Divider for ceil(depth / workers) = (depth + workers - 1) / workers.
  logic div_start, div_busy;
  logic [DW-1:0] div_q, div_num, div_dvs;
  assign div_num = DW'(depth_r) + DW'(workers) - DW'(1);
  assign div_dvs = DW'(workers);
  assign div_start = (state_r == S_DIV_GO);

  pdjs_divider #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(div_dvs), .busy(div_busy), .quotient(div_q)
  );

  // Scan evaluation of the pair read in the previous cycle.
  logic [SYM_W-1:0] pa, pb;
  logic a_ok, b_ok, hit;
  logic [IW-1:0] cur;
  assign pa = pair_q[2*SYM_W-1:SYM_W];
  assign pb = pair_q[SYM_W-1:0];
  assign cur = idx_r[IW-1:0];
  assign a_ok = (32'(pa) < MAX_SYMBOLS) && comp_r[pa[IW-1:0]];
  assign b_ok = (32'(pb) < MAX_SYMBOLS) && comp_r[pb[IW-1:0]];

  always_comb begin
    if (op_r == OP_START) begin
      hit = a_ok && b_ok;
    end else if (!pass_r) begin
      hit = (pb == sym_r) && a_ok && !added_r[cur];
    end else begin
      hit = (pa == sym_r) && b_ok && !added_r[cur];
    end
  end

  assign pair_raddr = idx_r[IW-1:0];
  assign pair_we = in_acc && (in_op == OP_LOAD) && (32'(in_symbol) < MAX_SYMBOLS);
  assign stack_we = (state_r == S_SCAN_EV) && hit && (depth_r < CW'(MAX_SYMBOLS));
  assign stack_raddr = IW'(depth_r - 1'b1);

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[in_symbol[IW-1:0]] <= {in_operand_first, in_operand_second};
    end
    pair_q <= pair_mem[pair_raddr];
    if (stack_we) begin
      stack_mem[depth_r[IW-1:0]] <= SYM_W'(idx_r);
    end
    stack_q <= stack_mem[stack_raddr];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    pass_nxt = pass_r;
    batch_nxt = batch_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt = orig_c;
          pass_nxt = 1'b0;
          if (in_op == OP_LOAD) begin
            state_nxt = S_OUT;
          end else if (in_op == OP_FETCH) begin
            state_nxt = S_DIV_GO;
          end else if (in_op == OP_DONE && 32'(in_symbol) >= MAX_SYMBOLS) begin
            state_nxt = S_OUT;
          end else if (in_op == OP_START) begin
            state_nxt = (orig_c < total_c) ? S_SCAN_RD : S_OUT;
          end else begin
            state_nxt = (orig_c < total_c) ? S_SCAN_RD : S_OUT;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (idx_r + 1'b1 < total_c) begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else if (op_r == OP_DONE && !pass_r) begin
          pass_nxt = 1'b1;
          idx_nxt = orig_c;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV_GO: begin
        if (CFG_W'(fetched_r) >= CFG_W'(total_c) || depth_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          batch_nxt = CW'(div_q);
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: state_nxt = S_POP_OUT;
      S_POP_OUT: begin
        if (out_free) begin
          batch_nxt = batch_r - 1'b1;
          state_nxt = (batch_r == CW'(1)) ? S_IDLE : S_POP_RD;
        end
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      depth_r <= '0;
      fetched_r <= CFG_W'(ORIG_RST);
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        comp_r[i] <= (i < ORIG_RST);
        added_r[i] <= (i < ORIG_RST);
      end
    end else begin
      state_r <= state_nxt;
      // In the pop-out and out states a new beat is loaded whenever the output
      // register is free; otherwise a taken beat empties it.
      if ((state_r == S_POP_OUT || state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && in_op == OP_START) begin
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
          comp_r[i] <= (CW'(i) < orig_c);
          added_r[i] <= (CW'(i) < orig_c);
        end
        depth_r <= '0;
        fetched_r <= CFG_W'(orig_c);
      end
      if (in_acc && in_op == OP_DONE && 32'(in_symbol) < MAX_SYMBOLS) begin
        comp_r[in_symbol[IW-1:0]] <= 1'b1;
      end
      if (state_r == S_SCAN_EV && hit) begin
        added_r[cur] <= 1'b1;
        if (depth_r < CW'(MAX_SYMBOLS)) depth_r <= depth_r + 1'b1;
      end
      if (state_r == S_DIV && !div_busy) begin
        fetched_r <= CFG_W'(fetched_r + div_q);
      end
      if (state_r == S_POP_OUT && out_free) begin
        depth_r <= depth_r - 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_op;
      sym_r <= in_symbol;
    end
    idx_r <= idx_nxt;
    pass_r <= pass_nxt;
    batch_r <= batch_nxt;
    if (state_r == S_POP_OUT && out_free) begin
      out_sym_r <= stack_q;
      out_st_r <= ST_JOB;
      out_last_r <= (batch_r == CW'(1));
    end else if (state_r == S_OUT && out_free) begin
      out_sym_r <= '0;
      out_last_r <= 1'b1;
      if (op_r != OP_FETCH) begin
        out_st_r <= ST_ACK;
      end else if (CFG_W'(fetched_r) >= CFG_W'(total_c)) begin
        out_st_r <= ST_ALLDONE;
      end else begin
        out_st_r <= ST_EMPTY;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_job_symbol = out_sym_r;
  assign out_status = out_st_r;
  assign out_last = out_last_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_acc)
    else $error("item accepted while the sequencer was busy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_OUT && out_free) |-> (depth_r != '0))
    else $error("pop from an empty ready stack");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(MAX_SYMBOLS))
    else $error("ready stack depth beyond capacity");
endmodule
